// ----- sv/bavt_pkg.sv -----
// Shared constants and types of the bandit arm value tracker.
package bavt_pkg;

  localparam int NUM_ARMS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int ARM_IDX_W  = $clog2(NUM_ARMS);
  localparam int MEAN_W     = 16;
  localparam int DIVD_W     = MEAN_W + 1;
  localparam int WORD_W     = COUNT_BITS + MEAN_W;

  typedef struct packed {
    logic                  start;
    logic [DIVD_W-1:0]     dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 clear;
    logic                 valid;
    logic [ARM_IDX_W-1:0] idx;
    logic [MEAN_W-1:0]    mean;
  } scan_in_t;

endpackage

// ----- sv/bavt_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module bavt_div import bavt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q;
  logic [DIVD_W-1:0]     quo_q, quo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : COUNT_BITS'(trial);
      quo_d  = {quo_q[DIVD_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) dvs_q <= req_i.divisor;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- sv/bavt_scan.sv -----
// Running maximum over a stream of arm means, lowest index kept on ties.
module bavt_scan import bavt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scan_in_t             scan_i,
  output logic [ARM_IDX_W-1:0] best_idx_o,
  output logic [MEAN_W-1:0]    best_mean_o
);

  logic [ARM_IDX_W-1:0] idx_q;
  logic [MEAN_W-1:0]    mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      mean_q <= '0;
    end else if (scan_i.clear) begin
      idx_q  <= '0;
      mean_q <= '0;
    end else if (scan_i.valid && (scan_i.mean > mean_q)) begin
      idx_q  <= scan_i.idx;
      mean_q <= scan_i.mean;
    end
  end

  assign best_idx_o  = idx_q;
  assign best_mean_o = mean_q;

endmodule

// ----- sv/bandit_arm_value_tracker.sv -----
// Bandit arm value tracker: per-arm play count and Q8.8 running mean.
//
// Input channel: arm_i and reward_i transfer at a rising edge where start
// is high and busy is low. busy stays high until the result has been shown.
// Output channel: one result per input, valid for exactly one cycle while
// done_o is high; the receiver cannot stall, so it must take it then.
// Per item the block reads the arm's count and mean from the state memory,
// forms reward*256 - mean, divides it by the updated count in a serial
// divider (one quotient bit a cycle), writes the entry back, then scans
// all NUM_ARMS entries through the single memory read port, one a cycle.
// A new item can transfer in the cycle after done_o. An arm index at or
// above NUM_ARMS skips the update and reports zero for the played fields.
// Reset clears the per-entry valid flags, so every count and mean reads as
// zero afterwards; no clearing pass is needed.
module bandit_arm_value_tracker import bavt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  arm_i,
  input  logic [7:0]  reward_i,
  output logic        done_o,
  output logic [3:0]  lead_arm_o,
  output logic [15:0] best_mean_o,
  output logic [15:0] played_mean_o,
  output logic [15:0] played_count_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [2:0] state_q, state_d;
  logic       accept;
  logic       in_range;

  logic [ARM_IDX_W-1:0]  arm_q;
  logic [7:0]            reward_q;
  logic [COUNT_BITS-1:0] cnt_new_q;
  logic [MEAN_W-1:0]     mean_old_q;
  logic                  neg_q;
  logic [MEAN_W-1:0]     mean_new_q;
  logic [MEAN_W-1:0]     pmean_q;
  logic [15:0]           pcount_q;
  logic [ARM_IDX_W-1:0]  scan_q;
  logic                  s_pend_q;
  logic [ARM_IDX_W-1:0]  s_idx_q;

  logic [WORD_W-1:0]    mem_q [NUM_ARMS];
  logic [WORD_W-1:0]    rd_data_q;
  logic [NUM_ARMS-1:0]  vld_q;
  logic                 rd_vld_q;
  logic                 mem_re;
  logic                 mem_we;
  logic [ARM_IDX_W-1:0] raddr;

  logic [WORD_W-1:0]     rd_word;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [MEAN_W-1:0]     cur_mean;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic signed [DIVD_W:0] diff;
  logic [DIVD_W-1:0]     diff_mag;
  logic [DIVD_W-1:0]     quot;
  logic [DIVD_W-1:0]     mean_sum;
  logic                  div_done;
  logic [ARM_IDX_W-1:0]  best_idx;
  logic [MEAN_W-1:0]     best_mean;

  div_req_t div_req;
  scan_in_t scan_in;

  assign accept   = start && !busy;
  assign in_range = 32'(arm_i) < NUM_ARMS;

  assign mem_re = (state_q == ST_RD) || (state_q == ST_SCAN);
  assign mem_we = (state_q == ST_WR);
  assign raddr  = (state_q == ST_SCAN) ? scan_q : arm_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[arm_q] <= {cnt_new_q, mean_new_q};
    if (mem_re) rd_data_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[arm_q] <= 1'b1;
      if (mem_re) rd_vld_q <= vld_q[raddr];
    end
  end

  assign rd_word  = rd_vld_q ? rd_data_q : '0;
  assign cur_cnt  = rd_word[WORD_W-1:MEAN_W];
  assign cur_mean = rd_word[MEAN_W-1:0];
  assign cnt_inc  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

  assign diff     = $signed({2'b00, reward_q, 8'h00}) - $signed({2'b00, cur_mean});
  assign diff_mag = diff[DIVD_W] ? DIVD_W'(-diff) : DIVD_W'(diff);

  assign div_req.start    = (state_q == ST_PREP);
  assign div_req.dividend = diff_mag;
  assign div_req.divisor  = cnt_inc;

  bavt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign mean_sum = neg_q ? ({1'b0, mean_old_q} - quot) : ({1'b0, mean_old_q} + quot);

  assign scan_in.clear = accept;
  assign scan_in.valid = s_pend_q;
  assign scan_in.idx   = s_idx_q;
  assign scan_in.mean  = cur_mean;

  bavt_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan_in),
    .best_idx_o  (best_idx),
    .best_mean_o (best_mean)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = in_range ? ST_RD : ST_SCAN;
      ST_RD:    state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_WR;
      ST_WR:    state_d = ST_SCAN;
      ST_SCAN:  if (scan_q == ARM_IDX_W'(NUM_ARMS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scan_q   <= '0;
      s_pend_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s_pend_q <= (state_q == ST_SCAN);
      if (state_q == ST_SCAN) scan_q <= scan_q + 1'b1;
      else                    scan_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    s_idx_q <= scan_q;
    if (accept) begin
      arm_q    <= ARM_IDX_W'(arm_i);
      reward_q <= reward_i;
      if (!in_range) begin
        pmean_q  <= '0;
        pcount_q <= '0;
      end
    end
    if (state_q == ST_PREP) begin
      cnt_new_q  <= cnt_inc;
      mean_old_q <= cur_mean;
      neg_q      <= diff[DIVD_W];
    end
    if ((state_q == ST_DIV) && div_done) mean_new_q <= MEAN_W'(mean_sum);
    if (state_q == ST_WR) begin
      pmean_q  <= mean_new_q;
      pcount_q <= (32'(cnt_new_q) > 32'hFFFF) ? 16'hFFFF : 16'(cnt_new_q);
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_OUT);
  assign lead_arm_o     = 4'(best_idx);
  assign best_mean_o    = best_mean;
  assign played_mean_o  = pmean_q;
  assign played_count_o = pcount_q;

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result strobe");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o) else $error("transfer did not start work");

  a_write_nonzero_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> cnt_new_q != '0) else $error("zero count written back");

  a_write_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> $past(div_done)) else $error("write back without quotient");

endmodule
